// File: design/chp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package chp_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int PERIM_W        = 34;
    localparam int STATUS_W       = 2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load_en;
        logic walk_init;
        logic start_cmp;
        logic start_done;
        logic pick_diff;
        logic pick_mul;
        logic pick_cmp;
        logic scan_next;
        logic sqrt_go;
        logic accum;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_acc;
        logic bad;
        logic scan_last;
        logic used_hit;
        logic have_best;
        logic sqrt_done;
        logic walk_end;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// File: design/convex_hull_perimeter.sv
`timescale 1ns / 1ps
`default_nettype none
// Convex hull perimeter by gift wrapping. Points stream in one item per cycle
// and are written to an on-chip store of MAX_POINTS entries; the item flagged
// by i_set_end closes the set. The block then stalls its input, finds the lowest
// (rightmost on ties) point, and walks the hull counterclockwise, picking at each
// vertex the unused point of smallest polar angle (nearest on equal angle) by
// exact cross products. One result item follows: the perimeter as a sum of
// per-segment lengths rounded to FRAC_BITS fraction bits (saturating at all
// ones), the number of segments walked, and a status (ok, fewer than two points,
// or store overflow; points beyond MAX_POINTS are dropped). After the last point,
// the start search reads and compares each point in turn, and each hull step scans
// every point, with a difference, multiply and compare for each unused one, through
// the single read port of the store, followed by the iterative square root of
// COORD_BITS+1+FRAC_BITS root bits (33 by default) and an accumulate step. A pending
// result waits in its output register while the next set loads.
module convex_hull_perimeter #(
    parameter int MAX_POINTS = chp_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = chp_pkg::FRAC_BITS_DEF,
    localparam int PW = $clog2(MAX_POINTS + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [COORD_BITS-1:0]  i_point_x,
    input  wire logic signed [COORD_BITS-1:0]  i_point_y,
    input  wire logic                          i_set_end,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [chp_pkg::PERIM_W-1:0]        o_perimeter,
    output logic [PW-1:0]                      o_hull_vertices,
    output logic [chp_pkg::STATUS_W-1:0]       o_status
);
    chp_pkg::t_cmd  cmd;
    chp_pkg::t_stat stat;

    // sequencer: load, start search, per-vertex scan, segment length, emit
    chp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // store, angle compare, square root and accumulation
    chp_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_set_end       (i_set_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_perimeter     (o_perimeter),
        .o_hull_vertices (o_hull_vertices),
        .o_status        (o_status)
    );

endmodule
`default_nettype wire

// File: design/chp_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module chp_sqrt #(
    parameter int RW = 33
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_go,
    input  wire logic [2*RW-1:0] i_rad,
    output logic                 o_done,
    output logic [RW:0]          o_len
);
    localparam int NW = 2 * RW;
    localparam int CW = $clog2(RW + 1);

    logic [NW-1:0] r_rad;
    logic [RW:0]   r_rem;
    logic [RW-1:0] r_root;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          fits;

    assign rem_sh = {r_rem[RW-1:0], r_rad[NW-1:NW-2]};
    assign trial  = {r_root, 2'b01};
    assign fits   = rem_sh >= trial;

    // one root bit per cycle, restoring recurrence
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= fits ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
            r_root <= {r_root[RW-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(RW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // round to nearest: bump when remainder exceeds root
    assign o_done = r_done;
    assign o_len  = {1'b0, r_root} + ((r_rem > {1'b0, r_root}) ? (RW+1)'(1) : (RW+1)'(0));

endmodule
`default_nettype wire

// File: design/chp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module chp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire chp_pkg::t_stat i_stat,
    output chp_pkg::t_cmd      o_cmd
);
    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_CHECK     = 13'b0000000000010,
        S_START_RD  = 13'b0000000000100,
        S_START_CMP = 13'b0000000001000,
        S_START_END = 13'b0000000010000,
        S_PICK_RD   = 13'b0000000100000,
        S_PICK_DIFF = 13'b0000001000000,
        S_PICK_MUL  = 13'b0000010000000,
        S_PICK_CMP  = 13'b0000100000000,
        S_PICK_END  = 13'b0001000000000,
        S_SQRT      = 13'b0010000000000,
        S_ACCUM     = 13'b0100000000000,
        S_EMIT      = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_en = 1'b1;
                if (i_stat.last_acc) n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.walk_init = 1'b1;
                n_state = i_stat.bad ? S_EMIT : S_START_RD;
            end
            S_START_RD: begin
                n_state = S_START_CMP;
            end
            S_START_CMP: begin
                o_cmd.start_cmp = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_START_END;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = S_START_RD;
                end
            end
            S_START_END: begin
                o_cmd.start_done = 1'b1;
                n_state = S_PICK_RD;
            end
            S_PICK_RD: begin
                if (!i_stat.used_hit) begin
                    n_state = S_PICK_DIFF;
                end else if (i_stat.scan_last) begin
                    n_state = S_PICK_END;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_PICK_DIFF: begin
                o_cmd.pick_diff = 1'b1;
                n_state = S_PICK_MUL;
            end
            S_PICK_MUL: begin
                o_cmd.pick_mul = 1'b1;
                n_state = S_PICK_CMP;
            end
            S_PICK_CMP: begin
                o_cmd.pick_cmp = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_PICK_END;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = S_PICK_RD;
                end
            end
            S_PICK_END: begin
                if (i_stat.have_best) begin
                    o_cmd.sqrt_go = 1'b1;
                    n_state = S_SQRT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SQRT: begin
                if (i_stat.sqrt_done) n_state = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state = i_stat.walk_end ? S_EMIT : S_PICK_RD;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: design/chp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module chp_datapath #(
    parameter int MAX_POINTS = chp_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = chp_pkg::FRAC_BITS_DEF,
    localparam int PW = $clog2(MAX_POINTS + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire chp_pkg::t_cmd                 i_cmd,
    output chp_pkg::t_stat                     o_stat,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [COORD_BITS-1:0]  i_point_x,
    input  wire logic signed [COORD_BITS-1:0]  i_point_y,
    input  wire logic                          i_set_end,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [chp_pkg::PERIM_W-1:0]        o_perimeter,
    output logic [PW-1:0]                      o_hull_vertices,
    output logic [chp_pkg::STATUS_W-1:0]       o_status
);
    localparam int C    = COORD_BITS;
    localparam int IW   = $clog2(MAX_POINTS);
    localparam int DW   = 2 * C + 2;
    localparam int RW   = C + 1 + FRAC_BITS;
    localparam int NW   = 2 * RW;
    localparam int LW   = RW + 1;
    localparam int SUMW = ((LW > chp_pkg::PERIM_W) ? LW : chp_pkg::PERIM_W) + 1;
    localparam logic [SUMW-1:0] SAT = SUMW'({chp_pkg::PERIM_W{1'b1}});

    logic signed [C-1:0] mem_x [MAX_POINTS];
    logic signed [C-1:0] mem_y [MAX_POINTS];
    logic signed [C-1:0] r_rd_x, r_rd_y;

    logic [PW-1:0]         r_count;
    logic                  r_over;
    logic [MAX_POINTS-1:0] r_used;
    logic [IW-1:0]         r_scan;
    logic                  accept, full;

    logic [IW-1:0]       r_start;
    logic signed [C-1:0] r_sx, r_sy;
    logic signed [C-1:0] r_cx, r_cy;
    logic                r_first;

    logic signed [C:0]    r_dx, r_dy, r_ax, r_ay;
    logic [IW-1:0]        r_cand;
    logic signed [C-1:0]  r_kx, r_ky;
    logic signed [DW-1:0] r_dxx, r_dyy, r_p1, r_p2;

    logic                r_have;
    logic [IW-1:0]       r_best;
    logic signed [C-1:0] r_bx, r_by;
    logic signed [C:0]   r_bax, r_bay;
    logic [DW-1:0]       r_bd;

    logic [SUMW-1:0] r_sum;
    logic [PW-1:0]   r_steps;

    logic signed [C:0]    dx, dy;
    logic                 zero_vec;
    logic [DW-1:0]        cand_d2;
    logic signed [DW:0]   cand_cr;
    logic                 ha, hb, ang_lt, ang_eq, take;
    logic                 sqrt_done;
    logic [LW-1:0]        seg_len;
    logic [SUMW-1:0]      sum_add;
    logic                 start_take;

    assign full       = r_count == PW'(MAX_POINTS);
    assign accept     = i_cmd.load_en & i_in_valid;
    assign o_in_stall = ~i_cmd.load_en;

    // point store: one write port during load, one read port during the walk
    always_ff @(posedge i_clk) begin
        if (accept && !full) begin
            mem_x[r_count[IW-1:0]] <= i_point_x;
            mem_y[r_count[IW-1:0]] <= i_point_y;
        end
        r_rd_x <= mem_x[r_scan];
        r_rd_y <= mem_y[r_scan];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_over  <= 1'b0;
            r_used  <= '0;
        end else begin
            if (accept) begin
                if (full) r_over <= 1'b1;
                else      r_count <= r_count + 1'b1;
            end
            if (i_cmd.start_done) r_used[r_start] <= 1'b1;
            if (i_cmd.accum) begin
                r_used[r_best] <= 1'b1;
                if (r_first) r_used[r_start] <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_count <= '0;
                r_over  <= 1'b0;
                r_used  <= '0;
            end
        end
    end

    // candidate difference, zero vector counts as angle zero
    assign dx       = (C+1)'(r_rd_x) - (C+1)'(r_cx);
    assign dy       = (C+1)'(r_rd_y) - (C+1)'(r_cy);
    assign zero_vec = (dx == '0) && (dy == '0);

    assign cand_d2 = DW'(r_dxx + r_dyy);
    assign cand_cr = (DW+1)'(r_p1) - (DW+1)'(r_p2);
    assign ha      = ~((r_ay > 0) || ((r_ay == 0) && (r_ax > 0)));
    assign hb      = ~((r_bay > 0) || ((r_bay == 0) && (r_bax > 0)));
    assign ang_lt  = (ha != hb) ? (!ha && hb) : (cand_cr > 0);
    assign ang_eq  = (ha == hb) && (cand_cr == 0);
    assign take    = !r_have || ang_lt || (ang_eq && (cand_d2 < r_bd));

    assign start_take = (r_scan == '0) || (r_rd_y < r_sy) ||
                        ((r_rd_y == r_sy) && (r_rd_x > r_sx));

    assign sum_add = r_sum + SUMW'(seg_len);

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_scan  <= '0;
            r_sum   <= '0;
            r_steps <= '0;
        end
        if (i_cmd.scan_next) r_scan <= r_scan + 1'b1;
        if (i_cmd.start_cmp && start_take) begin
            r_start <= r_scan;
            r_sx    <= r_rd_x;
            r_sy    <= r_rd_y;
        end
        if (i_cmd.start_done) begin
            r_cx    <= r_sx;
            r_cy    <= r_sy;
            r_first <= 1'b1;
            r_scan  <= '0;
            r_have  <= 1'b0;
        end
        if (i_cmd.pick_diff) begin
            r_dx   <= dx;
            r_dy   <= dy;
            r_ax   <= zero_vec ? (C+1)'(1) : dx;
            r_ay   <= dy;
            r_cand <= r_scan;
            r_kx   <= r_rd_x;
            r_ky   <= r_rd_y;
        end
        if (i_cmd.pick_mul) begin
            r_dxx <= r_dx * r_dx;
            r_dyy <= r_dy * r_dy;
            r_p1  <= r_ax * r_bay;
            r_p2  <= r_ay * r_bax;
        end
        if (i_cmd.pick_cmp && take) begin
            r_have <= 1'b1;
            r_best <= r_cand;
            r_bx   <= r_kx;
            r_by   <= r_ky;
            r_bax  <= r_ax;
            r_bay  <= r_ay;
            r_bd   <= cand_d2;
        end
        if (i_cmd.accum) begin
            r_sum   <= (sum_add > SAT) ? SAT : sum_add;
            r_steps <= r_steps + 1'b1;
            r_cx    <= r_bx;
            r_cy    <= r_by;
            r_first <= 1'b0;
            r_scan  <= '0;
            r_have  <= 1'b0;
        end
    end

    chp_sqrt #(
        .RW (RW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.sqrt_go),
        .i_rad   (NW'(r_bd) << (2 * FRAC_BITS)),
        .o_done  (sqrt_done),
        .o_len   (seg_len)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_perimeter     <= r_sum[chp_pkg::PERIM_W-1:0];
            o_hull_vertices <= r_steps;
            o_status        <= r_over ? chp_pkg::ST_OVER :
                               (r_count < PW'(2)) ? chp_pkg::ST_FEW : chp_pkg::ST_OK;
        end
    end

    always_comb begin
        o_stat.last_acc  = accept & i_set_end;
        o_stat.bad       = r_over || (r_count < PW'(2));
        o_stat.scan_last = (PW'(r_scan) + 1'b1) == r_count;
        o_stat.used_hit  = r_used[r_scan];
        o_stat.have_best = r_have;
        o_stat.sqrt_done = sqrt_done;
        o_stat.walk_end  = ((r_steps + 1'b1) >= r_count) ||
                           (!r_first && (r_bx == r_sx) && (r_by == r_sy));
        o_stat.out_free  = ~o_out_valid | ~i_out_stall;
    end

endmodule
`default_nettype wire
